### src/i2c_master_register_access_unit_macros.svh
`ifndef I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // Bus sequencer phases.
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_S_HIGH  = 4'd1;
  localparam logic [3:0] PH_S_FALL  = 4'd2;
  localparam logic [3:0] PH_S_LOW   = 4'd3;
  localparam logic [3:0] PH_B_LOW   = 4'd4;
  localparam logic [3:0] PH_B_HIGH  = 4'd5;
  localparam logic [3:0] PH_A_LOW   = 4'd6;
  localparam logic [3:0] PH_A_HIGH  = 4'd7;
  localparam logic [3:0] PH_RS_LOW  = 4'd8;
  localparam logic [3:0] PH_WAIT    = 4'd9;
  localparam logic [3:0] PH_RX_LOW  = 4'd10;
  localparam logic [3:0] PH_RX_HIGH = 4'd11;
  localparam logic [3:0] PH_M_LOW   = 4'd12;
  localparam logic [3:0] PH_M_HIGH  = 4'd13;
  localparam logic [3:0] PH_P_LOW   = 4'd14;
  localparam logic [3:0] PH_P_HIGH  = 4'd15;

  // Transaction stages.
  localparam logic [2:0] ST_ADDR_W = 3'd0;
  localparam logic [2:0] ST_REG    = 3'd1;
  localparam logic [2:0] ST_ADDR_R = 3'd2;
  localparam logic [2:0] ST_WDATA  = 3'd3;
  localparam logic [2:0] ST_RDATA  = 3'd4;
  localparam logic [2:0] ST_ABORT  = 3'd7;

  // Command codes.
  localparam logic [1:0] FN_TICK  = 2'd0;
  localparam logic [1:0] FN_WRITE = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;
  localparam logic [1:0] FN_DATA  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [1:0] CFG_POLL_LIMIT = 2'd1;
  localparam logic [1:0] CFG_ENABLE     = 2'd2;

  localparam logic [7:0] POLL_LIMIT_RESET = 8'd100;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] ack_poll_limit;
    logic       enable;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       need_data;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
    logic       ack_error;
    logic       cmd_error;
  } res_t;

endpackage

`default_nettype wire

### src/i2cm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  output i2cm_pkg::cfg_t     cfg
);
  import i2cm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= 7'd0;
      cfg.ack_poll_limit <= POLL_LIMIT_RESET;
      cfg.enable         <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEV_ADDR:   cfg.device_address <= cfg_data[6:0];
        CFG_POLL_LIMIT: cfg.ack_poll_limit <= cfg_data;
        CFG_ENABLE:     cfg.enable         <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/i2cm_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [1:0]    func,
  input  wire logic [7:0]    reg_addr,
  input  wire logic [7:0]    data_byte,
  input  wire logic [7:0]    byte_count,
  input  wire logic          sda_sample,
  input  i2cm_pkg::cfg_t     cfg,
  output i2cm_pkg::res_t     res
);
  import i2cm_pkg::*;

  logic [3:0] phase, phase_next;
  logic [2:0] stage, stage_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] saved_reg_addr, saved_reg_addr_next;
  logic       is_read, is_read_next;
  logic [7:0] poll_count, poll_count_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;

  logic       rd_valid, rd_last, done, abort_err, cmd_err, drive;
  logic [7:0] rd_data, shifted, rx_shift, tx_byte, bytes_dec;
  logic [3:0] bit_inc;

  always_comb begin
    phase_next          = phase;
    stage_next          = stage;
    bit_index_next      = bit_index;
    shift_reg_next      = shift_reg;
    bytes_left_next     = bytes_left;
    saved_reg_addr_next = saved_reg_addr;
    is_read_next        = is_read;
    poll_count_next     = poll_count;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    rd_valid            = 1'b0;
    rd_data             = 8'd0;
    rd_last             = 1'b0;
    done                = 1'b0;
    abort_err           = 1'b0;
    cmd_err             = 1'b0;

    shifted   = {shift_reg[6:0], 1'b0};
    rx_shift  = {shift_reg[6:0], sda_sample};
    bit_inc   = bit_index + 4'd1;
    bytes_dec = bytes_left - 8'd1;
    tx_byte   = {cfg.device_address, (stage == ST_ADDR_R)};

    if (func == FN_WRITE || func == FN_READ) begin
      if (!cfg.enable || phase != PH_IDLE || byte_count == 8'd0) begin
        cmd_err = 1'b1;
      end else begin
        saved_reg_addr_next = reg_addr;
        bytes_left_next     = byte_count;
        is_read_next        = (func == FN_READ);
        stage_next          = ST_ADDR_W;
        poll_count_next     = 8'd0;
        bit_index_next      = 4'd0;
        shift_reg_next      = 8'd0;
        phase_next          = PH_S_HIGH;
        scl_reg_next        = 1'b1;
        sda_reg_next        = 1'b1;
      end
    end else if (func == FN_DATA) begin
      if (phase == PH_WAIT) begin
        shift_reg_next = data_byte;
        bit_index_next = 4'd0;
        phase_next     = PH_B_LOW;
        scl_reg_next   = 1'b0;
        sda_reg_next   = data_byte[7];
      end
    end else begin
      unique case (phase)
        PH_IDLE, PH_WAIT: ;
        PH_S_HIGH: begin
          phase_next = PH_S_FALL; scl_reg_next = 1'b1; sda_reg_next = 1'b0;
        end
        PH_S_FALL: begin
          phase_next = PH_S_LOW; scl_reg_next = 1'b0; sda_reg_next = 1'b0;
        end
        PH_S_LOW: begin
          shift_reg_next = tx_byte;
          bit_index_next = 4'd0;
          phase_next     = PH_B_LOW;
          scl_reg_next   = 1'b0;
          sda_reg_next   = tx_byte[7];
        end
        PH_B_LOW: begin
          phase_next = PH_B_HIGH; scl_reg_next = 1'b1;
        end
        PH_B_HIGH: begin
          shift_reg_next = shifted;
          bit_index_next = bit_inc;
          scl_reg_next   = 1'b0;
          if (bit_inc < 4'd8) begin
            phase_next   = PH_B_LOW;
            sda_reg_next = shifted[7];
          end else begin
            poll_count_next = 8'd0;
            phase_next      = PH_A_LOW;
            sda_reg_next    = 1'b1;
          end
        end
        PH_A_LOW: begin
          phase_next = PH_A_HIGH; scl_reg_next = 1'b1; sda_reg_next = 1'b1;
        end
        PH_A_HIGH: begin
          if (!sda_sample) begin
            scl_reg_next = 1'b0;
            case (stage)
              ST_ADDR_W: begin
                stage_next     = ST_REG;
                shift_reg_next = saved_reg_addr;
                bit_index_next = 4'd0;
                phase_next     = PH_B_LOW;
                sda_reg_next   = saved_reg_addr[7];
              end
              ST_REG: begin
                if (is_read) begin
                  stage_next   = ST_ADDR_R;
                  phase_next   = PH_RS_LOW;
                  sda_reg_next = 1'b1;
                end else begin
                  stage_next   = ST_WDATA;
                  phase_next   = PH_WAIT;
                  sda_reg_next = 1'b0;
                end
              end
              ST_ADDR_R: begin
                stage_next     = ST_RDATA;
                shift_reg_next = 8'd0;
                bit_index_next = 4'd0;
                phase_next     = PH_RX_LOW;
                sda_reg_next   = 1'b1;
              end
              default: begin
                // Every data byte acknowledged counts down the transfer.
                bytes_left_next = bytes_dec;
                phase_next      = (bytes_dec == 8'd0) ? PH_P_LOW : PH_WAIT;
                sda_reg_next    = 1'b0;
              end
            endcase
          end else if (poll_count >= cfg.ack_poll_limit) begin
            stage_next   = ST_ABORT;
            phase_next   = PH_P_LOW;
            scl_reg_next = 1'b0;
            sda_reg_next = 1'b0;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end
        PH_RS_LOW: begin
          phase_next = PH_S_HIGH; scl_reg_next = 1'b1; sda_reg_next = 1'b1;
        end
        PH_RX_LOW: begin
          phase_next = PH_RX_HIGH; scl_reg_next = 1'b1; sda_reg_next = 1'b1;
        end
        PH_RX_HIGH: begin
          shift_reg_next = rx_shift;
          bit_index_next = bit_inc;
          scl_reg_next   = 1'b0;
          if (bit_inc < 4'd8) begin
            phase_next   = PH_RX_LOW;
            sda_reg_next = 1'b1;
          end else begin
            rd_valid     = 1'b1;
            rd_data      = rx_shift;
            rd_last      = (bytes_left == 8'd1);
            // NACK the last byte, ACK the others.
            phase_next   = PH_M_LOW;
            sda_reg_next = (bytes_left == 8'd1);
          end
        end
        PH_M_LOW: begin
          phase_next = PH_M_HIGH; scl_reg_next = 1'b1;
        end
        PH_M_HIGH: begin
          bytes_left_next = bytes_dec;
          scl_reg_next    = 1'b0;
          if (bytes_dec == 8'd0) begin
            phase_next   = PH_P_LOW;
            sda_reg_next = 1'b0;
          end else begin
            shift_reg_next = 8'd0;
            bit_index_next = 4'd0;
            phase_next     = PH_RX_LOW;
            sda_reg_next   = 1'b1;
          end
        end
        PH_P_LOW: begin
          phase_next = PH_P_HIGH; scl_reg_next = 1'b1; sda_reg_next = 1'b0;
        end
        PH_P_HIGH: begin
          done         = 1'b1;
          abort_err    = (stage == ST_ABORT);
          stage_next   = ST_ADDR_W;
          phase_next   = PH_IDLE;
          scl_reg_next = 1'b1;
          sda_reg_next = 1'b1;
        end
      endcase
    end

    drive = !(phase_next == PH_IDLE || phase_next == PH_A_LOW ||
              phase_next == PH_A_HIGH || phase_next == PH_RX_LOW ||
              phase_next == PH_RX_HIGH);

    res.scl_level  = scl_reg_next;
    res.sda_level  = drive ? sda_reg_next : 1'b1;
    res.sda_drive  = drive;
    res.busy_res   = (phase_next != PH_IDLE);
    res.need_data  = (phase_next == PH_WAIT);
    res.read_valid = rd_valid;
    res.read_data  = rd_data;
    res.read_last  = rd_last;
    res.done_res   = done;
    res.ack_error  = abort_err;
    res.cmd_error  = cmd_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= ST_ADDR_W;
      bit_index      <= 4'd0;
      shift_reg      <= 8'd0;
      bytes_left     <= 8'd0;
      saved_reg_addr <= 8'd0;
      is_read        <= 1'b0;
      poll_count     <= 8'd0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      stage          <= stage_next;
      bit_index      <= bit_index_next;
      shift_reg      <= shift_reg_next;
      bytes_left     <= bytes_left_next;
      saved_reg_addr <= saved_reg_addr_next;
      is_read        <= is_read_next;
      poll_count     <= poll_count_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
    end
  end

endmodule

`default_nettype wire

### src/i2cm_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_obuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  i2cm_pkg::res_t     push_res,
  output logic               space,
  output logic               out_valid,
  input  wire logic          out_ready,
  output i2cm_pkg::res_t     out_res
);
  import i2cm_pkg::*;

  logic skid_valid;
  res_t skid_res;
  logic pop;

  // The skid word lets the sequencer take one more word while the
  // output word is stalled.
  assign space = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_res <= skid_valid ? skid_res : push_res;
    end else if (push) begin
      skid_res <= push_res;
    end
  end

endmodule

`default_nettype wire

### src/i2c_master_register_access_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// I2C master register access unit.
// The input channel (in_valid/in_ready) takes one command word per cycle:
// a tick that advances the bus sequencer one phase step and carries the
// sampled SDA level, a begin-write or begin-read command, or a write data
// byte. Every accepted word produces exactly one result word on the output
// channel (out_valid/out_ready) with the SCL/SDA drive levels after the
// step and the status flags of that step.
// Each result word is registered in the output word, or in the skid word
// while that stalls; throughput is one word per cycle while in_ready is high.
// The configuration channel (cfg_valid/cfg_ready) is always ready and
// writes the device address, ACK poll limit and enable by index; write it
// only while no result is outstanding.
// Reset puts the bus idle with SCL and SDA released, clears the
// configuration except the poll limit, which comes up at 100, and empties
// the output words. When the receiver stalls, one more result word is held
// in a skid word, after which in_ready drops until the output drains.
module i2c_master_register_access_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] func,
  input  wire logic [7:0] reg_addr,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] byte_count,
  input  wire logic       sda_sample,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            scl_level,
  output logic            sda_level,
  output logic            sda_drive,
  output logic            busy_res,
  output logic            need_data,
  output logic            read_valid,
  output logic [7:0]      read_data,
  output logic            read_last,
  output logic            done_res,
  output logic            ack_error,
  output logic            cmd_error
);
  import i2cm_pkg::*;

  cfg_t cfg;
  res_t step_res;
  res_t out_res;
  logic step;

  assign step = in_valid && in_ready;

  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .func       (func),
    .reg_addr   (reg_addr),
    .data_byte  (data_byte),
    .byte_count (byte_count),
    .sda_sample (sda_sample),
    .cfg        (cfg),
    .res        (step_res)
  );

  i2cm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_res  (step_res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign scl_level  = out_res.scl_level;
  assign sda_level  = out_res.sda_level;
  assign sda_drive  = out_res.sda_drive;
  assign busy_res   = out_res.busy_res;
  assign need_data  = out_res.need_data;
  assign read_valid = out_res.read_valid;
  assign read_data  = out_res.read_data;
  assign read_last  = out_res.read_last;
  assign done_res   = out_res.done_res;
  assign ack_error  = out_res.ack_error;
  assign cmd_error  = out_res.cmd_error;

endmodule

`default_nettype wire

### src/i2cm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_register_access_unit_macros.svh"

module i2cm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic scl_level,
  input wire logic sda_level,
  input wire logic sda_drive,
  input wire logic busy_res,
  input wire logic need_data,
  input wire logic done_res,
  input wire logic ack_error
);

  // A stalled output word stays offered.
  `I2CM_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "output word dropped")

  // An accepted word always leaves a result word offered on the next cycle.
  `I2CM_ASSERT_NXT(a_result_follows, clk, rst, in_valid && in_ready, out_valid, "result word missing")

  // An idle bus is released on both lines.
  `I2CM_ASSERT_IMP(a_idle_bus, clk, rst, out_valid && !busy_res, scl_level && sda_level && !sda_drive, "idle bus not released")

  // While waiting for write data, SCL is held low with SDA driven.
  `I2CM_ASSERT_IMP(a_wait_bus, clk, rst, out_valid && need_data, !scl_level && sda_drive && busy_res, "bad bus level waiting for data")

  // An ACK timeout is only reported with the STOP that ends the transfer.
  `I2CM_ASSERT_IMP(a_err_done, clk, rst, out_valid && ack_error, done_res && !busy_res, "ack error without stop")

endmodule

bind i2c_master_register_access_unit i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .scl_level (scl_level),
  .sda_level (sda_level),
  .sda_drive (sda_drive),
  .busy_res  (busy_res),
  .need_data (need_data),
  .done_res  (done_res),
  .ack_error (ack_error)
);

`default_nettype wire
